// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 stream transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
  localparam logic [7:0]  LEAD2_MASK    = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE    = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK    = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE    = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK    = 8'hF8;
  localparam logic [7:0]  LEAD4_CODE    = 8'hF0;
  localparam logic [25:0] SUPP_OFFSET   = 26'h001_0000;
  localparam logic [15:0] HIGH_SURR     = 16'hD800;
  localparam logic [15:0] LOW_SURR      = 16'hDC00;

  localparam logic [1:0]  LEN_FOUR_BYTE = 2'd3;

  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  need;
    logic [1:0]  seq_len;
    logic [20:0] acc;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } unit_t;

endpackage

// ===== rtl/u8u16_in_if.sv =====
// ----------------------------------------------------------------------------
// u8u16_in_if
// Byte input channel: valid/ready handshake with one UTF-8 byte per item.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== rtl/u8u16_out_if.sv =====
// ----------------------------------------------------------------------------
// u8u16_out_if
// Code unit output channel: valid/ready handshake with one UTF-16 unit per item.
// ----------------------------------------------------------------------------
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;

  modport source (output valid, output code_unit, output run_last, input ready);
  modport sink   (input valid, input code_unit, input run_last, output ready);
endinterface

// ===== rtl/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte decode step: next sequence state and up to two UTF-16 units.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  u8u16_pkg::dec_state_t state_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  end_of_string_i,
  output u8u16_pkg::dec_state_t state_o,
  output logic [1:0]            n_units_o,
  output u8u16_pkg::unit_t      unit0_o,
  output u8u16_pkg::unit_t      unit1_o
);
  import u8u16_pkg::*;

  logic [20:0] acc_shift;
  logic [25:0] supp;

  assign acc_shift = {state_i.acc[14:0], in_byte_i[5:0]};
  assign supp      = {5'd0, acc_shift} - SUPP_OFFSET;

  always_comb begin
    state_o   = state_i;
    n_units_o = 2'd0;
    unit0_o   = '0;
    unit1_o   = '0;
    if (state_i.need != 2'd0) begin
      state_o.acc  = acc_shift;
      state_o.need = state_i.need - 2'd1;
      if (state_i.need == 2'd1) begin
        if (state_i.seq_len == LEN_FOUR_BYTE) begin
          unit0_o.code_unit = HIGH_SURR + supp[25:10];
          unit0_o.run_last  = 1'b0;
          unit1_o.code_unit = LOW_SURR + {6'd0, supp[9:0]};
          unit1_o.run_last  = 1'b1;
          n_units_o         = 2'd2;
        end else begin
          unit0_o.code_unit = acc_shift[15:0];
          unit0_o.run_last  = 1'b1;
          n_units_o         = 2'd1;
        end
        state_o = '0;
      end
    end else if (in_byte_i < ASCII_LIMIT) begin
      unit0_o.code_unit = {8'd0, in_byte_i};
      unit0_o.run_last  = 1'b1;
      n_units_o         = 2'd1;
    end else if ((in_byte_i & LEAD2_MASK) == LEAD2_CODE) begin
      state_o.acc     = {16'd0, in_byte_i[4:0]};
      state_o.need    = 2'd1;
      state_o.seq_len = 2'd1;
    end else if ((in_byte_i & LEAD3_MASK) == LEAD3_CODE) begin
      state_o.acc     = {17'd0, in_byte_i[3:0]};
      state_o.need    = 2'd2;
      state_o.seq_len = 2'd2;
    end else if ((in_byte_i & LEAD4_MASK) == LEAD4_CODE) begin
      state_o.acc     = {18'd0, in_byte_i[2:0]};
      state_o.need    = 2'd3;
      state_o.seq_len = LEN_FOUR_BYTE;
    end
    if (end_of_string_i && (state_o.need != 2'd0)) begin
      state_o = '0;
    end
  end

endmodule

// ===== rtl/utf8_to_utf16_stream_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_core
// Streaming UTF-8 to UTF-16 transcoder with valid/ready channels.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle while the queue has room and emits UTF-16
// code units, one per cycle while the output is ready. A byte is captured in
// an input register, decoded there against the open sequence state, and its
// units (none, one, or a surrogate pair) go into a four-entry result queue,
// which presents the first unit once it is written. Input throughput is one
// byte per cycle as long as the queue has two free entries; output is one
// unit per cycle, a surrogate pair going out as two units, so the sustained
// rate is set by the output port. Malformed input is not flagged; stray and
// invalid leads are skipped, and a sequence open at end of string is dropped.
module utf8_to_utf16_stream_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  u8u16_in_if.sink          in_i,
  u8u16_out_if.source       out_o
);
  import u8u16_pkg::*;

  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  eos_q;
  dec_state_t            state_q, state_d;
  logic [1:0]            n_units;
  unit_t                 unit0, unit1;

  unit_t                 queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]     count_q, count_d;
  logic                  pop, advance, take;
  logic [1:0]            n_write;

  u8u16_decode u_decode (
    .state_i         (state_q),
    .in_byte_i       (in_byte_q),
    .end_of_string_i (eos_q),
    .state_o         (state_d),
    .n_units_o       (n_units),
    .unit0_o         (unit0),
    .unit1_o         (unit1)
  );

  assign pop     = out_o.valid && out_o.ready;
  assign advance = in_valid_q &&
                   ((count_q - QCNT_W'(pop)) <= QCNT_W'(QUEUE_DEPTH - 2));
  assign take    = in_i.valid && in_i.ready;
  assign n_write = advance ? n_units : 2'd0;
  assign count_d = count_q + QCNT_W'(n_write) - QCNT_W'(pop);

  assign in_i.ready      = !in_valid_q || advance;
  assign out_o.valid     = count_q != '0;
  assign out_o.code_unit = queue_q[rd_ptr_q].code_unit;
  assign out_o.run_last  = queue_q[rd_ptr_q].run_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
      wr_ptr_q <= wr_ptr_q + QPTR_W'(n_write);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= in_i.in_byte;
      eos_q     <= in_i.end_of_string;
    end
    if (n_write != 2'd0) begin
      queue_q[wr_ptr_q] <= unit0;
    end
    if (n_write == 2'd2) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= unit1;
    end
  end

endmodule

// ===== tb/tb_utf8_to_utf16_stream_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_stream_core
// Self-checking bench for the streaming UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes (ASCII extremes, stray and invalid leads,
// two-, three- and four-byte codes, out-of-range surrogate math, truncation at
// end of string) is followed by random strings built mostly from well-formed
// sequences with random payload, mixed with noise bytes and cut-off strings.
// Every accepted byte runs through a local decoder model; each unit leaving the
// core is compared with the oldest pending prediction. The sender idles in
// random bursts, the receiver stalls on its own pattern and holds off for long
// stretches so the core's queue fills and back-pressures the byte input.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_stream_core;
  import u8u16_pkg::*;

  localparam int unsigned RANDOM_BYTES = 900;
  localparam int unsigned HOLD_CYCLES  = 90;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0]  b;
    logic        eos;
    logic        typed;
    logic [1:0]  n;
    logic [15:0] u0;
    logic [15:0] u1;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY3, RX_SPARSE} rx_mode_e;

  localparam int unsigned DIR_ROWS = 24;

  // typed rows carry their units; the rest go through the decoder model
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000},
    '{8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F, 16'h0000},
    '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
    '{8'hF8, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
    '{8'hFF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
    '{8'hC2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h82, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hAC, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h9F, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h98, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hF7, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hBF, 1'b0, 1'b1, 2'd2, 16'hDFBF, 16'hDFFF},
    '{8'hC2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h41, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
    '{8'h82, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000},
    '{8'hC3, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000},
    '{8'h5A, 1'b1, 1'b1, 2'd1, 16'h005A, 16'h0000}
  };

  logic clk;
  logic rst_n;

  u8u16_in_if  byte_ch ();
  u8u16_out_if unit_ch ();

  utf8_to_utf16_stream_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (unit_ch)
  );

  dec_state_t  decoder;
  unit_t       pending_units [$];
  int unsigned mismatches;
  int unsigned bytes_in;
  int unsigned units_checked;
  int unsigned pairs_predicted;
  int unsigned strings_ended;
  int unsigned burst_left;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // decoder model: advances the sequence state, returns units completed
  function automatic int decode_byte(input logic [7:0] b, input logic eos,
                                     output logic [15:0] u0, output logic [15:0] u1);
    logic [31:0] offs;
    logic [31:0] high_w;
    int          n;
    n  = 0;
    u0 = '0;
    u1 = '0;
    if (decoder.need != 2'd0) begin
      decoder.acc  = {decoder.acc[14:0], b[5:0]};
      decoder.need = decoder.need - 2'd1;
      if (decoder.need == 2'd0) begin
        if (decoder.seq_len == LEN_FOUR_BYTE) begin
          offs   = {11'd0, decoder.acc} - {6'd0, SUPP_OFFSET};
          high_w = {16'd0, HIGH_SURR} + (offs >> 10);
          u0     = high_w[15:0];
          u1     = LOW_SURR + {6'd0, offs[9:0]};
          n      = 2;
        end else begin
          u0 = decoder.acc[15:0];
          n  = 1;
        end
        decoder = '0;
      end
    end else if (b < ASCII_LIMIT) begin
      u0 = {8'h00, b};
      n  = 1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      decoder = '{need: 2'd1, seq_len: 2'd1, acc: {16'd0, b[4:0]}};
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      decoder = '{need: 2'd2, seq_len: 2'd2, acc: {17'd0, b[3:0]}};
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      decoder = '{need: 2'd3, seq_len: 2'd3, acc: {18'd0, b[2:0]}};
    end
    if (eos && decoder.need != 2'd0) begin
      decoder = '0;
    end
    return n;
  endfunction

  task automatic push_units(input int n, input logic [15:0] u0, input logic [15:0] u1);
    if (n == 1) begin
      pending_units.push_back('{code_unit: u0, run_last: 1'b1});
    end else if (n == 2) begin
      pending_units.push_back('{code_unit: u0, run_last: 1'b0});
      pending_units.push_back('{code_unit: u1, run_last: 1'b1});
      pairs_predicted++;
    end
  endtask

  // offer one byte in the current burst; predict once it is taken
  task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed,
                           input int typed_n, input logic [15:0] t0,
                           input logic [15:0] t1);
    int          gap;
    int          n;
    logic [15:0] p0;
    logic [15:0] p1;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_ch.valid         <= 1'b1;
    byte_ch.in_byte       <= b;
    byte_ch.end_of_string <= eos;
    do @(posedge clk); while (!byte_ch.ready);
    n = decode_byte(b, eos, p0, p1);
    if (typed) begin
      push_units(typed_n, t0, t1);
    end else begin
      push_units(n, p0, p1);
    end
    bytes_in++;
    if (eos) begin
      strings_ended++;
    end
  endtask

  function automatic logic [7:0] tail_byte();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  initial begin : byte_source
    logic [7:0] seq [$];
    int         kind;
    int         cut;
    bit         end_here;
    byte_ch.valid         <= 1'b0;
    byte_ch.in_byte       <= 8'h00;
    byte_ch.end_of_string <= 1'b0;
    decoder    = '0;
    burst_left = 0;
    steady     = 1'b0;
    @(posedge rst_n);
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed,
                int'(dir_rows[i].n), dir_rows[i].u0, dir_rows[i].u1);
    end

    while (bytes_in < DIR_ROWS + RANDOM_BYTES) begin
      if ((bytes_in % 100) == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      seq.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        seq.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 40) begin
        seq.push_back({1'b0, 7'($urandom_range(0, 127))});
      end else if (kind < 62) begin
        seq.push_back({3'b110, 5'($urandom_range(0, 31))});
        seq.push_back(tail_byte());
      end else if (kind < 82) begin
        seq.push_back({4'b1110, 4'($urandom_range(0, 15))});
        repeat (2) seq.push_back(tail_byte());
      end else begin
        seq.push_back({5'b11110, 3'($urandom_range(0, 7))});
        repeat (3) seq.push_back(tail_byte());
      end
      cut = seq.size() - 1;
      if (seq.size() > 1 && $urandom_range(0, 19) == 0) begin
        cut = $urandom_range(0, seq.size() - 2);
      end
      end_here = (cut != seq.size() - 1) || ($urandom_range(0, 7) == 0);
      for (int k = 0; k <= cut; k++) begin
        send_byte(seq[k], end_here && (k == cut), 1'b0, 0, 16'h0000, 16'h0000);
      end
    end
    byte_ch.valid <= 1'b0;

    while (pending_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes in %0d ended strings; %0d units checked, %0d surrogate pairs",
             bytes_in, strings_ended, units_checked, pairs_predicted);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: stall pattern redrawn at random from four modes, plus long hold-offs
  initial begin : unit_sink
    int unsigned cyc;
    int unsigned hold;
    rx_mode_e    mode;
    unit_ch.ready <= 1'b0;
    cyc  = 0;
    hold = 0;
    mode = RX_OPEN;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if ((cyc % 64) == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
      end
      if (cyc == 300 || cyc == 2500 || cyc == 6000) begin
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        unit_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN: begin
            unit_ch.ready <= 1'b1;
          end
          RX_COIN: begin
            unit_ch.ready <= 1'($urandom_range(0, 1));
          end
          RX_EVERY3: begin
            unit_ch.ready <= ((cyc % 3) != 0);
          end
          default: begin
            unit_ch.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : unit_check
    unit_t want;
    if (rst_n && unit_ch.valid && unit_ch.ready) begin
      if (pending_units.size() == 0) begin
        $error("unexpected unit: code_unit %h run_last %b",
               unit_ch.code_unit, unit_ch.run_last);
        mismatches++;
      end else begin
        want = pending_units.pop_front();
        units_checked++;
        if (unit_ch.code_unit !== want.code_unit) begin
          $error("code_unit: expected %h, got %h", want.code_unit, unit_ch.code_unit);
          mismatches++;
        end
        if (unit_ch.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, unit_ch.run_last);
          mismatches++;
        end
      end
    end
  end

endmodule
